/* design/jros_pkg.sv */
// Shared constants, codes and types for the JSON root-object splitter.
package jros_pkg;

  // Configured nesting limit; the depth counter is 8 bits, so the limit saturates at 255
  localparam int unsigned MaxDepth   = 255;
  localparam int unsigned LevelWidth = 8;
  localparam logic [LevelWidth-1:0] DepthLimit =
    (MaxDepth > 255) ? 8'd255 : LevelWidth'(MaxDepth);

  // Character codes
  localparam logic [7:0] ChOpenBracket  = 8'h5B;  // [
  localparam logic [7:0] ChCloseBracket = 8'h5D;  // ]
  localparam logic [7:0] ChComma        = 8'h2C;  // ,
  localparam logic [7:0] ChSpace        = 8'h20;
  localparam logic [7:0] ChLineFeed     = 8'h0A;
  localparam logic [7:0] ChCarriageRet  = 8'h0D;
  localparam logic [7:0] ChTab          = 8'h09;
  localparam logic [7:0] ChOpenBrace    = 8'h7B;  // {
  localparam logic [7:0] ChCloseBrace   = 8'h7D;  // }
  localparam logic [7:0] ChQuote        = 8'h22;  // "
  localparam logic [7:0] ChBackslash    = 8'h5C;

  // Final status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNMATCHED = 2'd1,
    STATUS_TRUNCATED = 2'd2,
    STATUS_TOO_DEEP  = 2'd3
  } status_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       object_last;
    logic       stream_done;
    status_t    status;
  } result_t;

endpackage

/* design/jros_stream_if.sv */
// Valid/ready channel interfaces for the input bytes and the result items.
interface jros_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jros_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       object_last;
  logic       stream_done;
  logic [1:0] status;

  modport source (output valid, output out_byte, output object_last,
                  output stream_done, output status, input ready);
  modport sink   (input valid, input out_byte, input object_last,
                  input stream_done, input status, output ready);
endinterface

/* design/json_root_object_splitter_top.sv */
// Top level of the JSON root-object splitter.
//
// in_ch carries one JSON byte per transfer (data_byte), or an end marker
// (end_of_input) that asks for the final status. out_ch carries the bytes of
// each root-level object, with object_last on the closing brace, and
// status-only items (stream_done, status) for errors and end of stream.
// Root-level brackets, commas and whitespace produce no output item.
//
// Throughput: one input byte per cycle while the output register can load. The
// depth/string/escape state updates in the cycle of the transfer, and the result
// lands in a single output register, so out_ch.valid rises in the cycle after.
// in_ch.ready follows the output register: it is high when that register is
// empty or is being emptied by out_ch in the same cycle. A stalled receiver
// therefore holds the input after one item is buffered.
// After an unmatched '}' or excessive nesting the block drops bytes until an
// end marker, which reports the status and clears all state.
// Reset (rst, synchronous) clears the scanner state and empties the output.
module json_root_object_splitter_top (
  input  logic       clk,
  input  logic       rst,
  jros_in_if.sink    in_ch,
  jros_out_if.source out_ch
);
  import jros_pkg::*;

  logic    take;
  logic    emit;
  logic    can_load;
  result_t result;

  assign in_ch.ready = can_load;
  assign take        = in_ch.valid && can_load;

  jros_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (in_ch.data_byte),
    .end_of_input (in_ch.end_of_input),
    .emit         (emit),
    .result       (result)
  );

  jros_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && emit),
    .load_data (result),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

/* design/jros_parser.sv */
// Scanner state (depth, string, escape, halt) and the per-byte result decode.
module jros_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_input,
  output logic              emit,
  output jros_pkg::result_t result
);
  import jros_pkg::*;

  logic [LevelWidth-1:0] nest_level, nest_level_next;
  logic                  inside_string, inside_string_next;
  logic                  pending_escape, pending_escape_next;
  logic                  halted, halted_next;
  logic                  root_delim;

  // Delimiters dropped at root level
  assign root_delim = (nest_level == '0) &&
                      (data_byte inside {ChOpenBracket, ChCloseBracket, ChComma, ChSpace,
                                         ChLineFeed, ChCarriageRet, ChTab});

  // Decode one byte against the current state
  always_comb begin
    nest_level_next     = nest_level;
    inside_string_next  = inside_string;
    pending_escape_next = pending_escape;
    halted_next         = halted;
    emit                = 1'b0;
    result.out_byte     = data_byte;
    result.object_last  = 1'b0;
    result.stream_done  = 1'b0;
    result.status       = STATUS_OK;

    if (end_of_input) begin
      emit               = 1'b1;
      result.out_byte    = 8'd0;
      result.stream_done = 1'b1;
      if (halted) begin
        result.status = (nest_level == '0) ? STATUS_UNMATCHED : STATUS_TOO_DEEP;
      end else begin
        result.status = (nest_level != '0) ? STATUS_TRUNCATED : STATUS_OK;
      end
      nest_level_next     = '0;
      inside_string_next  = 1'b0;
      pending_escape_next = 1'b0;
      halted_next         = 1'b0;
    end else if (!halted && !root_delim) begin
      emit = 1'b1;
      if (pending_escape) begin
        pending_escape_next = 1'b0;
      end else if (data_byte == ChBackslash && inside_string) begin
        pending_escape_next = 1'b1;
      end else if (data_byte == ChQuote) begin
        inside_string_next = !inside_string;
      end else if (!inside_string) begin
        if (data_byte == ChOpenBrace) begin
          if (nest_level >= DepthLimit) begin
            halted_next        = 1'b1;
            result.out_byte    = 8'd0;
            result.stream_done = 1'b1;
            result.status      = STATUS_TOO_DEEP;
          end else begin
            nest_level_next = nest_level + 1'b1;
          end
        end else if (data_byte == ChCloseBrace) begin
          if (nest_level == '0) begin
            halted_next        = 1'b1;
            result.out_byte    = 8'd0;
            result.stream_done = 1'b1;
            result.status      = STATUS_UNMATCHED;
          end else begin
            nest_level_next    = nest_level - 1'b1;
            result.object_last = (nest_level == LevelWidth'(1));
          end
        end
      end
    end
  end

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      nest_level     <= '0;
      inside_string  <= 1'b0;
      pending_escape <= 1'b0;
      halted         <= 1'b0;
    end else if (take) begin
      nest_level     <= nest_level_next;
      inside_string  <= inside_string_next;
      pending_escape <= pending_escape_next;
      halted         <= halted_next;
    end
  end

endmodule

/* design/jros_out_stage.sv */
// Result register that holds one item until the receiver takes it.
module jros_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jros_pkg::result_t load_data,
  output logic              can_load,
  jros_out_if.source        out_ch
);
  import jros_pkg::*;

  logic    valid;
  result_t data;

  // Free when empty or when the held item leaves this cycle
  assign can_load = !valid || out_ch.ready;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data <= load_data;
    end
  end

  assign out_ch.valid       = valid;
  assign out_ch.out_byte    = data.out_byte;
  assign out_ch.object_last = data.object_last;
  assign out_ch.stream_done = data.stream_done;
  assign out_ch.status      = data.status;

endmodule

/* design/jros_checker.sv */
// Port-level assertions for the splitter and their bind to the top level.
module jros_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       object_last,
  input logic       stream_done,
  input logic [1:0] status
);
  import jros_pkg::*;

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
    else $error("stalled result changed");

  // Plain byte results carry ok status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !stream_done |-> status == STATUS_OK)
    else $error("byte result with nonzero status");

  // Only a closing brace ends an object
  assert property (@(posedge clk) disable iff (rst)
    out_valid && object_last |-> out_byte == ChCloseBrace && !stream_done)
    else $error("object_last on wrong byte");

  // Status-only results carry no byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> out_byte == 8'd0 && !object_last)
    else $error("status result carries data");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind json_root_object_splitter_top jros_checker u_jros_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .object_last (out_ch.object_last),
  .stream_done (out_ch.stream_done),
  .status      (out_ch.status)
);
